FILE: hdl/ttbt_pkg.sv
// ----------------------------------------------------------------------------
// Tap tempo beat tracker package
// Shared constants, configuration register codes and the divider status type.
// ----------------------------------------------------------------------------
`default_nettype none

package ttbt_pkg;

	// Default parameter values
	localparam int TAP_DEPTH_DEF  = 4;
	localparam int TIME_WIDTH_DEF = 32;

	// Width of the divisor and of the beat period
	localparam int PER_W = 12;

	// Fixed constants of the tracker
	localparam logic [7:0]       HUE_STEP     = 8'd57;
	localparam logic [7:0]       BRIGHT_MAX   = 8'd140;
	localparam logic [PER_W-1:0] TAP_RESET    = 12'd750;
	localparam logic [PER_W-1:0] PERIOD_RESET = 12'd1000;
	localparam logic [3:0]       SHIFT_RESET  = 4'd4;
	localparam int               TAP_WINDOW   = 4;

	// Configuration reset values
	localparam logic [11:0] MIN_BEAT_RESET  = 12'd300;
	localparam logic [11:0] MAX_BEAT_RESET  = 12'd1500;
	localparam logic [7:0]  LOOP_RESET      = 8'd20;
	localparam logic [15:0] STALL_RESET     = 16'd3000;
	localparam logic [3:0]  MAX_SHIFT_RESET = 4'd8;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_MIN_BEAT  = 3'd0,
		CFG_MAX_BEAT  = 3'd1,
		CFG_LOOP      = 3'd2,
		CFG_STALL     = 3'd3,
		CFG_MAX_SHIFT = 3'd4
	} cfg_idx_t;

	// Status of the shared divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

FILE: hdl/ttbt_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle; quotient and remainder hold after done.
// ----------------------------------------------------------------------------
`default_nettype none

module ttbt_div #(
	parameter int DW = 32
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [DW-1:0]              dividend,
	input  wire logic [ttbt_pkg::PER_W-1:0] divisor,
	output ttbt_pkg::div_stat_t             stat,
	output logic [DW-1:0]                   quotient,
	output logic [ttbt_pkg::PER_W-1:0]      remainder
);
	import ttbt_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0]    quo_q;
	logic [PER_W-1:0] rem_q;
	logic [PER_W-1:0] dsr_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [PER_W:0]   trial;
	logic             fits;

	// Trial subtraction of the divisor from the shifted partial remainder
	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	// Control: counter and busy and done flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CW'(DW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? PER_W'(trial - {1'b0, dsr_q}) : trial[PER_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

FILE: hdl/tap_tempo_beat_tracker.sv
// ----------------------------------------------------------------------------
// Tap tempo beat tracker
// Tracks pause, beat grid, tap tempo and shift learning for one tick per beat.
// ----------------------------------------------------------------------------
// Usage: one input beat on the s_ channel per tick carries the millisecond
// time and the pause, tap and shift levels; one output beat on the m_
// channel carries the tick's results. The cfg channel writes the five
// configuration registers and is always ready; write it only while idle.
// Each tick is worked through by a small sequencer around one shared
// restoring divider of DW bits, with DW the larger of TIME_WIDTH and 20.
// A paused tick goes from the pause step straight to the output step. A
// running tick also waits on the divider for each division it needs (tap
// interval, realignment, shift modulo, brightness), and a tap inside the
// tempo window adds a step that loads the new mean. s_tready is high only
// while the sequencer is idle, which it re-enters as the result is issued.
// The result sits in an output register: a stalled receiver does not stop
// the next tick being taken, but the sequencer holds at its final step
// until the previous result has been taken.
// Reset returns all tracking state to its start values at once and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_tempo_beat_tracker #(
	parameter int TAP_DEPTH  = ttbt_pkg::TAP_DEPTH_DEF,
	parameter int TIME_WIDTH = ttbt_pkg::TIME_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_tdata from bit 0: now_ms[32], pause_level[8], beat_level[8], shift_level[8]
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,
	// m_tdata from bit 0: paused[1], beat_now[1], half_beat_now[1],
	// partial_shift[1], auto_shift[2], manual_shift[2], shift_beats[4],
	// beats_since_auto[8], time_since_beat[32], beat_interval[16],
	// beat_brightness[8], beat_hue[8], zero fill[4]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	import ttbt_pkg::*;

	localparam int TW    = TIME_WIDTH;
	localparam int DW    = (TW > 20) ? TW : 20;
	localparam int SUM_W = PER_W + $clog2(TAP_DEPTH + 1);

	// Reciprocal of the tap depth, rounded up, exact for every SUM_W-bit sum
	localparam int          TAP_L  = $clog2(TAP_DEPTH);
	localparam int          RC_SH  = SUM_W + TAP_L;
	localparam int          RC_W   = RC_SH + 1;
	localparam logic [63:0] RC_M64 =
		((64'd1 << RC_SH) + 64'(TAP_DEPTH) - 64'd1) / 64'(TAP_DEPTH);
	localparam logic [RC_W-1:0] RC_M = RC_M64[RC_W-1:0];

	typedef enum logic [19:0] {
		S_IDLE  = 20'b00000000000000000001,
		S_PAUSE = 20'b00000000000000000010,
		S_EFF   = 20'b00000000000000000100,
		S_STALL = 20'b00000000000000001000,
		S_BEAT  = 20'b00000000000000010000,
		S_HALF  = 20'b00000000000000100000,
		S_HALF2 = 20'b00000000000001000000,
		S_TDIV  = 20'b00000000000010000000,
		S_SUM   = 20'b00000000000100000000,
		S_TAP   = 20'b00000000001000000000,
		S_REAL  = 20'b00000000010000000000,
		S_REAL2 = 20'b00000000100000000000,
		S_RWAIT = 20'b00000001000000000000,
		S_CNT   = 20'b00000010000000000000,
		S_MOD   = 20'b00000100000000000000,
		S_MWAIT = 20'b00001000000000000000,
		S_AUTO  = 20'b00010000000000000000,
		S_MAN   = 20'b00100000000000000000,
		S_BWAIT = 20'b01000000000000000000,
		S_OUT   = 20'b10000000000000000000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [11:0] min_beat_q, max_beat_q;
	logic [7:0]  loop_q;
	logic [15:0] stall_q;
	logic [3:0]  max_shift_q;

	// Tracking state
	logic [TW-1:0]    pause_total_q, pause_begin_q, prev_frame_q;
	logic [TW-1:0]    beat_time_q, next_beat_q, pending_q, tap_time_q;
	logic             was_paused_q, pending_valid_q;
	logic [PER_W-1:0] beat_period_q;
	logic [7:0]       prev_beat_lv_q, prev_shift_lv_q;
	logic [7:0]       auto_count_q, manual_count_q, hue_q;
	logic [3:0]       shift_period_q;
	logic [PER_W-1:0] hist_q [TAP_DEPTH];
	logic [SUM_W-1:0] tap_sum_q;

	// Per-tick working registers
	logic [TW-1:0] now_q, eff_q, half_q, tsl_q, lim_q, gap_q;
	logic [7:0]    pause_lv_q, beat_lv_q, shift_lv_q;
	logic          beat_q, halfb_q, close_q, partial_q, shift_chg_q, manual_do_q;
	logic [1:0]    autos_q, manuals_q;
	logic [7:0]    bright_q;

	// Divider interface
	div_stat_t        div_stat;
	logic             div_start;
	logic [DW-1:0]    div_dvd;
	logic [PER_W-1:0] div_dsr;
	logic [DW-1:0]    div_quo;
	logic [PER_W-1:0] div_rem;

	// Helpers
	logic                  tap_ev;
	logic [PER_W-1:0]      clamp_v;
	logic                  shift_ok;
	logic [8:0]            mc9, sp9;
	logic                  out_free;
	logic [SUM_W+RC_W-1:0] mean_prod;

	ttbt_div #(.DW(DW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid || m_tready;

	// Mean of the tap history by multiplication with the reciprocal
	assign mean_prod = (SUM_W+RC_W)'(tap_sum_q) * (SUM_W+RC_W)'(RC_M);

	// Tap detection, interval clamp and shift learning condition
	assign tap_ev = (beat_lv_q == 8'd1) && (prev_beat_lv_q != 8'd1);
	assign mc9    = {1'b0, manual_count_q};
	assign sp9    = {5'b0, shift_period_q};

	always_comb begin
		if (tsl_q < TW'(min_beat_q)) begin
			clamp_v = min_beat_q;
		end else if (tsl_q > TW'(max_beat_q)) begin
			clamp_v = max_beat_q;
		end else begin
			clamp_v = tsl_q[PER_W-1:0];
		end
		shift_ok = ((shift_period_q == 4'd0) && (mc9 <= {5'b0, max_shift_q})) ||
			((mc9 + 9'd1 > sp9) && (mc9 < sp9 + 9'd2));
	end

	// Divider operand selection per launching step
	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dsr   = beat_period_q;
		unique case (state_q)
			S_HALF2: begin
				div_start = tap_ev && (beat_period_q != '0);
				div_dvd   = DW'(tsl_q);
			end
			S_REAL2: begin
				div_start = (lim_q >= next_beat_q) && (beat_period_q != '0);
				div_dvd   = DW'(lim_q - next_beat_q);
			end
			S_MOD: begin
				div_start = shift_chg_q &&
					((manual_count_q != 8'd0) || (shift_period_q == 4'd0));
				div_dvd   = DW'(manual_count_q);
				div_dsr   = PER_W'({1'b0, max_shift_q} + 5'd1);
			end
			S_MAN: begin
				div_start = (beat_period_q != '0) && (gap_q < TW'(beat_period_q));
				div_dvd   = DW'(BRIGHT_MAX) * DW'(gap_q[PER_W-1:0]);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_beat_q  <= MIN_BEAT_RESET;
			max_beat_q  <= MAX_BEAT_RESET;
			loop_q      <= LOOP_RESET;
			stall_q     <= STALL_RESET;
			max_shift_q <= MAX_SHIFT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MIN_BEAT:  min_beat_q  <= cfg_data[11:0];
				CFG_MAX_BEAT:  max_beat_q  <= cfg_data[11:0];
				CFG_LOOP:      loop_q      <= cfg_data[7:0];
				CFG_STALL:     stall_q     <= cfg_data;
				CFG_MAX_SHIFT: max_shift_q <= cfg_data[3:0];
				default:       ;
			endcase
		end
	end

	// Sequencer and tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			pause_total_q   <= '0;
			pause_begin_q   <= '0;
			prev_frame_q    <= '0;
			beat_time_q     <= '0;
			next_beat_q     <= '0;
			pending_q       <= '0;
			tap_time_q      <= '0;
			was_paused_q    <= 1'b0;
			pending_valid_q <= 1'b0;
			beat_period_q   <= PERIOD_RESET;
			prev_beat_lv_q  <= '0;
			prev_shift_lv_q <= '0;
			auto_count_q    <= '0;
			manual_count_q  <= '0;
			hue_q           <= '0;
			shift_period_q  <= SHIFT_RESET;
			for (int i = 0; i < TAP_DEPTH; i++) hist_q[i] <= TAP_RESET;
			tap_sum_q       <= SUM_W'(TAP_DEPTH) * SUM_W'(TAP_RESET);
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_PAUSE;
				end
				// Paused ticks freeze the effect clock
				S_PAUSE: begin
					if (pause_lv_q == 8'd1) begin
						if (!was_paused_q) pause_begin_q <= now_q;
						was_paused_q <= 1'b1;
						state_q      <= S_OUT;
					end else begin
						if (was_paused_q)
							pause_total_q <= pause_total_q + (now_q - pause_begin_q);
						was_paused_q <= 1'b0;
						state_q      <= S_EFF;
					end
				end
				S_EFF: begin
					eff_q   <= now_q - pause_total_q;
					state_q <= S_STALL;
				end
				// Resynchronise the beat grid after a long gap
				S_STALL: begin
					if ((eff_q - prev_frame_q) > TW'(stall_q)) begin
						prev_frame_q <= now_q - TW'(loop_q);
						eff_q        <= now_q;
						beat_time_q  <= now_q;
						next_beat_q  <= now_q + TW'(beat_period_q);
					end
					state_q <= S_BEAT;
				end
				S_BEAT: begin
					beat_q <= (eff_q >= next_beat_q);
					if (eff_q >= next_beat_q) begin
						beat_time_q <= next_beat_q;
						if (pending_valid_q) begin
							next_beat_q     <= pending_q;
							pending_valid_q <= 1'b0;
						end else begin
							next_beat_q <= next_beat_q + TW'(beat_period_q);
						end
					end
					state_q <= S_HALF;
				end
				S_HALF: begin
					half_q  <= beat_time_q + ((next_beat_q - beat_time_q) >> 1);
					tsl_q   <= eff_q - tap_time_q;
					close_q <= (next_beat_q - eff_q) < TW'({loop_q, 2'b00});
					state_q <= S_HALF2;
				end
				// Half-beat crossing and tap decision
				S_HALF2: begin
					halfb_q        <= (eff_q >= half_q) && (prev_frame_q < half_q);
					prev_beat_lv_q <= beat_lv_q;
					if (!tap_ev) state_q <= S_REAL;
					else if (beat_period_q != '0) state_q <= S_TDIV;
					else state_q <= S_TAP;
				end
				// Tap interval within the window updates the mean
				S_TDIV: begin
					if (div_stat.done) begin
						if (div_quo < DW'(TAP_WINDOW)) begin
							tap_sum_q <= tap_sum_q - SUM_W'(hist_q[0]) + SUM_W'(clamp_v);
							for (int i = 0; i + 1 < TAP_DEPTH; i++) hist_q[i] <= hist_q[i+1];
							hist_q[TAP_DEPTH-1] <= clamp_v;
							state_q <= S_SUM;
						end else begin
							state_q <= S_TAP;
						end
					end
				end
				S_SUM: begin
					beat_period_q <= mean_prod[RC_SH +: PER_W];
					state_q       <= S_TAP;
				end
				// Re-phase the grid on the tap, or defer to a later beat
				S_TAP: begin
					if (beat_q || close_q) begin
						beat_q      <= 1'b1;
						beat_time_q <= eff_q;
						next_beat_q <= eff_q + TW'(beat_period_q);
					end else begin
						pending_q       <= eff_q + TW'({beat_period_q, 1'b0});
						pending_valid_q <= 1'b1;
					end
					tap_time_q <= eff_q;
					state_q    <= S_REAL;
				end
				S_REAL: begin
					lim_q   <= beat_time_q + TW'(min_beat_q);
					state_q <= S_REAL2;
				end
				S_REAL2: begin
					state_q <= div_start ? S_RWAIT : S_CNT;
				end
				// next + (q+1)*period equals lim - remainder + period
				S_RWAIT: begin
					if (div_stat.done) begin
						next_beat_q <= lim_q - TW'(div_rem) + TW'(beat_period_q);
						state_q     <= S_CNT;
					end
				end
				S_CNT: begin
					if (beat_q) begin
						if (auto_count_q != 8'd255) auto_count_q <= auto_count_q + 8'd1;
						if (manual_count_q != 8'd255) manual_count_q <= manual_count_q + 8'd1;
						hue_q <= hue_q + HUE_STEP;
					end
					shift_chg_q     <= shift_lv_q != prev_shift_lv_q;
					prev_shift_lv_q <= shift_lv_q;
					state_q         <= S_MOD;
				end
				S_MOD: begin
					manual_do_q <= 1'b0;
					state_q     <= div_start ? S_MWAIT : S_AUTO;
				end
				// Learn beats per shift from a manual press
				S_MWAIT: begin
					if (div_stat.done) begin
						if (shift_ok) begin
							shift_period_q <= div_rem[3:0];
							manual_do_q    <= 1'b1;
						end else if (manual_count_q > 8'd1) begin
							shift_period_q <= 4'd0;
							manual_do_q    <= 1'b1;
						end
						state_q <= S_AUTO;
					end
				end
				// Partial and automatic shifts
				S_AUTO: begin
					if ((shift_period_q != 4'd0) && beat_q &&
						(auto_count_q >= {4'b0, shift_period_q})) begin
						autos_q      <= (manual_count_q < 8'd2) ? 2'd2 : 2'd1;
						auto_count_q <= '0;
					end else begin
						autos_q <= 2'd0;
					end
					partial_q <= (shift_period_q != 4'd0) &&
						(auto_count_q == {5'b0, shift_period_q[3:1]}) &&
						((beat_q && !shift_period_q[0]) || (halfb_q && shift_period_q[0]));
					gap_q   <= eff_q - beat_time_q;
					state_q <= S_MAN;
				end
				// Manual shift flag, then brightness
				S_MAN: begin
					if (manual_do_q) begin
						manuals_q      <= (auto_count_q < 8'd2) ? 2'd2 : 2'd1;
						manual_count_q <= '0;
					end else begin
						manuals_q <= 2'd0;
					end
					prev_frame_q <= eff_q;
					bright_q     <= '0;
					state_q      <= div_start ? S_BWAIT : S_OUT;
				end
				S_BWAIT: begin
					if (div_stat.done) begin
						bright_q <= BRIGHT_MAX - div_quo[7:0];
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result valid: raised as the result is loaded, dropped once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Input capture
	logic is_paused_q;
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_q      <= TW'(s_tdata[31:0]);
			pause_lv_q <= s_tdata[39:32];
			beat_lv_q  <= s_tdata[47:40];
			shift_lv_q <= s_tdata[55:48];
		end
		if (state_q == S_PAUSE) is_paused_q <= (pause_lv_q == 8'd1);
	end

	// Output register
	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			if (is_paused_q) begin
				m_tdata <= {87'b0, 1'b1};
			end else begin
				m_tdata <= {4'b0, hue_q, bright_q, 16'(next_beat_q - beat_time_q),
					32'(gap_q), auto_count_q, shift_period_q, manuals_q, autos_q,
					partial_q, halfb_q, beat_q, 1'b0};
			end
		end
	end

endmodule

`default_nettype wire
